// ===== hdl/ptla_pkg.sv =====
package ptla_pkg;

    localparam int LINE_REGS     = 4;
    localparam int NUM_LINES_DEF = 4;
    localparam int IDX_W         = $clog2(LINE_REGS);
    localparam int COORD_W       = 16;
    localparam int PROD_W        = 2 * COORD_W;
    localparam int SUM_W         = PROD_W + 2;
    localparam int DIST_W        = 32;
    localparam int FRAC_SHIFT    = 14;
    localparam int INTERVAL_W    = 16;
    localparam int MODE_W        = 3;
    localparam int CFG_ADDR_W    = 3;
    localparam int CFG_DATA_W    = 48;

    localparam logic [CFG_ADDR_W-1:0] REG_LINE_ZERO  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LINE_ONE   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LINE_TWO   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_LINE_THREE = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_INTERVAL   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_MODE       = 3'd5;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd16;
    localparam logic [MODE_W-1:0]     MODE_NEAREST   = 3'd0;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [DIST_W-1:0]         dist_t;
    typedef logic [IDX_W-1:0]          idx_t;
    typedef logic [LINE_REGS-1:0]      mask_t;

    // a in the low bits, c in the high bits
    typedef struct packed {
        coord_t c;
        coord_t b;
        coord_t a;
    } line_t;

endpackage

// ===== hdl/ptla_dist.sv =====
module ptla_dist
    import ptla_pkg::*;
#(
    parameter int SCAN_LINES = NUM_LINES_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  line_t  lines [LINE_REGS],
    input  logic   in_valid,
    output logic   in_ready,
    input  coord_t in_x,
    input  coord_t in_y,
    output logic   out_valid,
    input  logic   out_ready,
    output coord_t out_x,
    output coord_t out_y,
    output dist_t  out_dist [LINE_REGS]
);

    logic                     a_v_reg;
    coord_t                   a_x_reg;
    coord_t                   a_y_reg;
    logic signed [PROD_W-1:0] ax_reg [LINE_REGS];
    logic signed [PROD_W-1:0] by_reg [LINE_REGS];

    logic   b_v_reg;
    coord_t b_x_reg;
    coord_t b_y_reg;
    dist_t  dist_reg [LINE_REGS];
    dist_t  dist_next [LINE_REGS];

    logic en_a;
    logic en_b;

    assign en_b     = !b_v_reg || out_ready;
    assign en_a     = !a_v_reg || en_b;
    assign in_ready = en_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
                a_v_reg <= in_valid;
            if (en_b)
                b_v_reg <= a_v_reg;
        end
    end

    // stage A: products
    always_ff @(posedge clk)
    begin
        if (en_a && in_valid)
        begin
            a_x_reg <= in_x;
            a_y_reg <= in_y;
            for (int i = 0; i < LINE_REGS; i++)
            begin
                ax_reg[i] <= PROD_W'(lines[i].a) * PROD_W'(in_x);
                by_reg[i] <= PROD_W'(lines[i].b) * PROD_W'(in_y);
            end
        end
    end

    // stage B: |a*x + b*y + c*2^14|
    always_comb
    begin
        logic signed [SUM_W-1:0] sum;
        for (int i = 0; i < LINE_REGS; i++)
        begin
            sum = SUM_W'(ax_reg[i]) + SUM_W'(by_reg[i])
                + (SUM_W'(lines[i].c) <<< FRAC_SHIFT);
            if (i < SCAN_LINES)
                dist_next[i] = sum[SUM_W-1] ? DIST_W'(-sum) : DIST_W'(sum);
            else
                dist_next[i] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_b && a_v_reg)
        begin
            b_x_reg <= a_x_reg;
            b_y_reg <= a_y_reg;
            for (int i = 0; i < LINE_REGS; i++)
                dist_reg[i] <= dist_next[i];
        end
    end

    assign out_valid = b_v_reg;
    assign out_x     = b_x_reg;
    assign out_y     = b_y_reg;
    assign out_dist  = dist_reg;

endmodule

// ===== hdl/ptla_pick.sv =====
module ptla_pick
    import ptla_pkg::*;
#(
    parameter int SCAN_LINES = NUM_LINES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [INTERVAL_W-1:0] interval,
    input  logic [MODE_W-1:0]     mode,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  coord_t                in_x,
    input  coord_t                in_y,
    input  dist_t                 in_dist [LINE_REGS],
    output logic                  out_valid,
    input  logic                  out_ready,
    output coord_t                out_x,
    output coord_t                out_y,
    output mask_t                 out_mask,
    output logic [MODE_W-1:0]     out_count
);

    localparam mask_t PRESENT = mask_t'((1 << SCAN_LINES) - 1);

    logic   c_v_reg;
    coord_t c_x_reg;
    coord_t c_y_reg;
    mask_t  within_reg;
    mask_t  within_next;
    idx_t   lo_idx_reg;
    idx_t   lo_idx_next;
    dist_t  lo_dist_reg;
    idx_t   hi_idx_reg;
    idx_t   hi_idx_next;
    dist_t  hi_dist_reg;

    logic              d_v_reg;
    coord_t            d_x_reg;
    coord_t            d_y_reg;
    mask_t             mask_reg;
    mask_t             mask_next;
    logic [MODE_W-1:0] count_reg;
    logic [MODE_W-1:0] count_next;

    logic en_c;
    logic en_d;

    assign en_d     = !d_v_reg || out_ready;
    assign en_c     = !c_v_reg || en_d;
    assign in_ready = en_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
        end
        else
        begin
            if (en_c)
                c_v_reg <= in_valid;
            if (en_d)
                d_v_reg <= c_v_reg;
        end
    end

    // stage C: interval flags, pairwise minimum (tie to higher index)
    always_comb
    begin
        logic [DIST_W-1:0] limit;
        limit = DIST_W'({interval, FRAC_SHIFT'(0)});
        for (int i = 0; i < LINE_REGS; i++)
            within_next[i] = PRESENT[i] && (in_dist[i] <= limit);
        lo_idx_next = (in_dist[0] < in_dist[1]) ? idx_t'(0) : idx_t'(1);
        if (!PRESENT[3] || (in_dist[2] < in_dist[3]))
            hi_idx_next = idx_t'(2);
        else
            hi_idx_next = idx_t'(3);
    end

    always_ff @(posedge clk)
    begin
        if (en_c && in_valid)
        begin
            c_x_reg     <= in_x;
            c_y_reg     <= in_y;
            within_reg  <= within_next;
            lo_idx_reg  <= lo_idx_next;
            lo_dist_reg <= in_dist[lo_idx_next];
            hi_idx_reg  <= hi_idx_next;
            hi_dist_reg <= in_dist[hi_idx_next];
        end
    end

    // stage D: final choice
    always_comb
    begin
        logic [MODE_W-1:0] taken;
        idx_t              best;
        mask_next  = '0;
        count_next = '0;
        taken      = '0;
        if (mode == MODE_NEAREST)
        begin
            if (!PRESENT[2] || (lo_dist_reg < hi_dist_reg))
                best = lo_idx_reg;
            else
                best = hi_idx_reg;
            mask_next  = mask_t'(1) << best;
            count_next = MODE_W'(1);
        end
        else
        begin
            best = '0;
            for (int j = LINE_REGS - 1; j >= 0; j--)
            begin
                if (within_reg[j] && (taken < mode))
                begin
                    mask_next[j] = 1'b1;
                    taken        = taken + MODE_W'(1);
                end
            end
            count_next = taken;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_d && c_v_reg)
        begin
            d_x_reg   <= c_x_reg;
            d_y_reg   <= c_y_reg;
            mask_reg  <= mask_next;
            count_reg <= count_next;
        end
    end

    assign out_valid = d_v_reg;
    assign out_x     = d_x_reg;
    assign out_y     = d_y_reg;
    assign out_mask  = mask_reg;
    assign out_count = count_reg;

endmodule

// ===== hdl/point_to_line_assignment.sv =====
// Assigns each streamed point to up to four configured lines by the distance
// |A*x + B*y + C| (lines given normalised, A and B Q1.14, x, y and C Q12.4).
// One point per clock is accepted unless back-pressure holds the pipeline; each
// point passes four register stages (products, sum and magnitude, interval test
// with pairwise minimum, then the final choice in the output register) and its
// result is offered once it reaches the output register. Back-pressure stalls
// each stage only when it is full. Write the line, interval and mode registers
// only while no point is in flight.
module point_to_line_assignment
    import ptla_pkg::*;
#(
    parameter int NUM_LINES = NUM_LINES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // point_x, point_y
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata,   // out_x, out_y, line_mask, match_count, pad
    input  logic                  cfg_wen,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int SCAN_LINES = (NUM_LINES < LINE_REGS) ? NUM_LINES : LINE_REGS;

    line_t                 line_reg [LINE_REGS];
    logic [INTERVAL_W-1:0] interval_reg;
    logic [MODE_W-1:0]     mode_reg;

    logic   mid_valid;
    logic   mid_ready;
    coord_t mid_x;
    coord_t mid_y;
    dist_t  mid_dist [LINE_REGS];

    coord_t            res_x;
    coord_t            res_y;
    mask_t             res_mask;
    logic [MODE_W-1:0] res_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LINE_REGS; i++)
                line_reg[i] <= '0;
            interval_reg <= INTERVAL_RESET;
            mode_reg     <= MODE_NEAREST;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_addr) inside
                REG_LINE_ZERO, REG_LINE_ONE, REG_LINE_TWO, REG_LINE_THREE:
                    line_reg[cfg_addr[IDX_W-1:0]] <= line_t'(cfg_wdata);
                REG_INTERVAL:
                    interval_reg <= cfg_wdata[INTERVAL_W-1:0];
                REG_MODE:
                    mode_reg <= cfg_wdata[MODE_W-1:0];
                default:
                    ;
            endcase
        end
    end

    ptla_dist #(
        .SCAN_LINES (SCAN_LINES)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .lines     (line_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_x      (coord_t'(s_tdata[15:0])),
        .in_y      (coord_t'(s_tdata[31:16])),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_x     (mid_x),
        .out_y     (mid_y),
        .out_dist  (mid_dist)
    );

    ptla_pick #(
        .SCAN_LINES (SCAN_LINES)
    ) u_pick (
        .clk       (clk),
        .rst_n     (rst_n),
        .interval  (interval_reg),
        .mode      (mode_reg),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_x      (mid_x),
        .in_y      (mid_y),
        .in_dist   (mid_dist),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_x     (res_x),
        .out_y     (res_y),
        .out_mask  (res_mask),
        .out_count (res_count)
    );

    assign m_tdata = {1'b0, res_count, res_mask, res_y, res_x};

endmodule
